// File: rtl/jac_pkg.sv
package jac_pkg;

	localparam int CAL_W = 10;
	localparam int DEN_W = 10;
	localparam int POS_W = 9;

	typedef logic [1:0] axis_t;

	localparam axis_t AXIS_YAW   = 2'd0;
	localparam axis_t AXIS_PITCH = 2'd1;
	localparam axis_t AXIS_ROLL  = 2'd2;
	localparam axis_t AXIS_ELEV  = 2'd3;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_YAW   = 2'd0;
	localparam reg_idx_t REG_PITCH = 2'd1;
	localparam reg_idx_t REG_ROLL  = 2'd2;
	localparam reg_idx_t REG_ELEV  = 2'd3;

	localparam logic [29:0] YAW_CAL_RST   = 30'd986666808;
	localparam logic [29:0] PITCH_CAL_RST = 30'd525190334;
	localparam logic [29:0] ROLL_CAL_RST  = 30'd1012895569;
	localparam logic [19:0] ELEV_CAL_RST  = 20'd904486;

	typedef struct packed {
		logic [29:0] yaw;
		logic [29:0] pitch;
		logic [29:0] roll;
		logic [19:0] elev;
	} cal_set_t;

endpackage

// File: rtl/jac_front.sv
module jac_front #(
	parameter int ADC_BITS   = 10,
	parameter int OVERSAMPLE = 8,
	parameter int SUM_W      = 13,
	parameter int CNT_W      = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  logic [9:0]           sample,
	input  jac_pkg::axis_t       mode,
	output logic                 q_push,
	output logic [SUM_W+1:0]     q_data,
	input  logic                 q_ready
);
	import jac_pkg::*;

	localparam logic [9:0] SMASK = 10'((1 << ADC_BITS) - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OVERSAMPLE - 1);

	logic [SUM_W-1:0] sum_q [4];
	logic [CNT_W-1:0] cnt_q [4];
	logic [SUM_W-1:0] sum_new;
	logic             last;
	logic             accept;

	always_comb begin
		sum_new      = sum_q[mode] + SUM_W'(sample & SMASK);
		last         = cnt_q[mode] == CNT_LAST;
		sample_ready = q_ready;
		accept       = sample_valid && q_ready;
		q_push       = accept && last;
		q_data       = {mode, sum_new};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (accept) begin
			if (last) begin
				sum_q[mode] <= '0;
				cnt_q[mode] <= '0;
			end else begin
				sum_q[mode] <= sum_new;
				cnt_q[mode] <= cnt_q[mode] + 1'b1;
			end
		end
	end

endmodule

// File: rtl/jac_fifo.sv
module jac_fifo #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         pop_valid
);
	import jac_pkg::*;

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/jac_div.sv
module jac_div #(
	parameter int NW = 20,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	import jac_pkg::*;

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   trial_sub;
	logic          ge;

	always_comb begin
		trial     = {rem_q, quo_q[NW-1]};
		trial_sub = trial - {1'b0, den_q};
		ge        = trial >= {1'b0, den_q};
	end

	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/jac_back.sv
module jac_back #(
	parameter int ADC_BITS   = 10,
	parameter int OVERSAMPLE = 8,
	parameter int OUT_BITS   = 8,
	parameter int SUM_W      = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  logic [SUM_W+1:0]      q_data,
	input  jac_pkg::cal_set_t     cal,
	output logic                  result_valid,
	input  logic                  result_ready,
	output jac_pkg::axis_t        axis,
	output logic signed [8:0]     position,
	output logic                  cal_error
);
	import jac_pkg::*;

	localparam int XW    = (ADC_BITS > CAL_W) ? ADC_BITS : CAL_W;
	localparam int MAG_W = XW + ADC_BITS;
	localparam int NW    = (MAG_W > SUM_W) ? MAG_W : SUM_W;
	localparam int SHIFT = (ADC_BITS > OUT_BITS) ? ADC_BITS - OUT_BITS : 0;
	localparam int PW    = (OUT_BITS + 1 > POS_W) ? OUT_BITS + 1 : POS_W;
	localparam int REC_S = SUM_W + $clog2(OVERSAMPLE);
	localparam int REC_W = SUM_W + 1;
	localparam int PRD_W = SUM_W + REC_W;

	localparam logic [XW-1:0]       FULL_X    = XW'((1 << ADC_BITS) - 1);
	localparam logic [ADC_BITS-1:0] K_FULL    = ADC_BITS'((1 << ADC_BITS) - 1);
	localparam logic [ADC_BITS-1:0] K_HALF    = ADC_BITS'(1 << (ADC_BITS - 1));
	localparam logic [ADC_BITS-1:0] K_HALF_M1 = ADC_BITS'((1 << (ADC_BITS - 1)) - 1);
	localparam logic [NW-1:0]       LIM_E     = NW'((1 << OUT_BITS) - 1);
	localparam logic [NW-1:0]       LIM_P     = NW'((1 << (OUT_BITS - 1)) - 1);
	localparam logic [NW-1:0]       LIM_N     = NW'(1 << (OUT_BITS - 1));
	localparam logic [REC_W-1:0]    REC_M     =
		REC_W'(((1 << REC_S) + OVERSAMPLE - 1) / OVERSAMPLE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_MUL,
		ST_START,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t              state_q;
	axis_t               axis_q;
	logic [XW-1:0]       avg_q;
	logic [XW-1:0]       dmag_q;
	logic [ADC_BITS-1:0] k_q;
	logic [DEN_W-1:0]    den_q;
	logic                neg_q;
	logic                err_q;
	logic [MAG_W-1:0]    prod_q;
	logic                res_valid_q;
	axis_t               res_axis_q;
	logic [8:0]          res_pos_q;
	logic                res_err_q;

	logic                div_start;
	logic [NW-1:0]       div_num;
	logic [DEN_W-1:0]    div_den;
	logic                div_done;
	logic [NW-1:0]       div_quo;

	logic [PRD_W-1:0]    avg_prod;
	logic [29:0]         word;
	logic [CAL_W-1:0]    c_mn;
	logic [CAL_W-1:0]    c_mx;
	logic [CAL_W-1:0]    c_rest;
	logic [XW-1:0]       avg_x;
	logic [XW-1:0]       x_e;
	logic                above;
	logic [XW:0]         dd;
	logic [CAL_W:0]      ee;
	logic [ADC_BITS-1:0] k_sel;
	logic [XW-1:0]       dmag;
	logic [DEN_W-1:0]    emag;
	logic [NW-1:0]       red;
	logic [NW-1:0]       mag_c;
	logic [PW-1:0]       pv;
	logic                out_free;

	jac_div #(
		.NW(NW),
		.DW(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		q_pop     = (state_q == ST_IDLE) && q_valid;
		avg_prod  = PRD_W'(q_data[SUM_W-1:0]) * PRD_W'(REC_M);
		div_start = (state_q == ST_START);
		div_num   = NW'(prod_q);
		div_den   = den_q;
	end

	always_comb begin
		case (axis_q)
			AXIS_YAW:   word = cal.yaw;
			AXIS_PITCH: word = cal.pitch;
			AXIS_ROLL:  word = cal.roll;
			default:    word = {10'd0, cal.elev};
		endcase
		c_mn   = word[9:0];
		c_mx   = word[19:10];
		c_rest = word[29:20];
		avg_x  = avg_q;
		x_e    = FULL_X - avg_x;
		above  = avg_x > XW'(c_rest);
		if (axis_q == AXIS_ELEV) begin
			dd    = {1'b0, x_e} - {1'b0, XW'(c_mn)};
			ee    = {1'b0, c_mx} - {1'b0, c_mn};
			k_sel = K_FULL;
		end else if (above) begin
			dd    = {1'b0, avg_x} - {1'b0, XW'(c_rest)};
			ee    = {1'b0, c_mx} - {1'b0, c_rest};
			k_sel = K_HALF_M1;
		end else begin
			dd    = {1'b0, XW'(c_rest)} - {1'b0, avg_x};
			ee    = {1'b0, c_mn} - {1'b0, c_rest};
			k_sel = K_HALF;
		end
		dmag = dd[XW] ? XW'(~dd + 1'b1) : dd[XW-1:0];
		emag = ee[CAL_W] ? DEN_W'(~ee + 1'b1) : ee[DEN_W-1:0];
	end

	always_comb begin
		red = div_quo >> SHIFT;
		if (axis_q == AXIS_ELEV) begin
			mag_c = neg_q ? '0 : ((red > LIM_E) ? LIM_E : red);
		end else if (neg_q) begin
			mag_c = (red > LIM_N) ? LIM_N : red;
		end else begin
			mag_c = (red > LIM_P) ? LIM_P : red;
		end
		pv = PW'(mag_c);
		if (neg_q) begin
			pv = -pv;
		end
		if (err_q) begin
			pv = '0;
		end
		out_free = !res_valid_q || result_ready;
	end

	assign result_valid = res_valid_q;
	assign axis         = res_axis_q;
	assign position     = $signed(res_pos_q);
	assign cal_error    = res_err_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			axis_q <= q_data[SUM_W+1:SUM_W];
			avg_q  <= XW'(avg_prod >> REC_S);
		end
		if (state_q == ST_AVG) begin
			dmag_q <= dmag;
			k_q    <= k_sel;
			den_q  <= emag;
			neg_q  <= dd[XW] ^ ee[CAL_W];
			err_q  <= ee == '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= MAG_W'(dmag_q) * MAG_W'(k_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_axis_q  <= AXIS_YAW;
			res_pos_q   <= '0;
			res_err_q   <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
				res_axis_q  <= axis_q;
				res_pos_q   <= pv[8:0];
				res_err_q   <= err_q;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: state_q <= (ee == '0) ? ST_OUT : ST_MUL;
				ST_MUL: state_q <= ST_START;
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/joystick_axis_calibrator_core.sv
// Channel  Handshake                   Payload
// sample   sample_valid/sample_ready   sample, mode
// result   result_valid/result_ready   axis, position, cal_error
// config   psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// The front takes one sample per cycle and queues each completed axis (two entries).
// The back takes one axis at a time: IDLE, AVG, MUL, START, DIV, OUT, with an NW-bit
// divider, NW = max(max(ADC_BITS,10)+ADC_BITS, sum width); AVG goes to OUT on a zero span.
// Reset clears all sums and counts at once and loads default calibration.
// The front stalls only while the queue is full; the back holds a finished
// result in its output register until it is taken.
module joystick_axis_calibrator_core #(
	parameter int ADC_BITS   = 10,
	parameter int OVERSAMPLE = 8,
	parameter int OUT_BITS   = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  logic [9:0]           sample,
	input  jac_pkg::axis_t       mode,
	output logic                 result_valid,
	input  logic                 result_ready,
	output jac_pkg::axis_t       axis,
	output logic signed [8:0]    position,
	output logic                 cal_error
);
	import jac_pkg::*;

	localparam int SUM_W = $clog2(OVERSAMPLE * 1023 + 1);
	localparam int CNT_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

	logic [29:0]      yaw_cal_q;
	logic [29:0]      pitch_cal_q;
	logic [29:0]      roll_cal_q;
	logic [19:0]      elev_cal_q;
	cal_set_t         cal;
	logic             cfg_wr;
	reg_idx_t         reg_idx;

	logic             q_push;
	logic [SUM_W+1:0] q_push_data;
	logic             q_ready;
	logic             q_pop;
	logic [SUM_W+1:0] q_pop_data;
	logic             q_valid;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cal     = '{yaw: yaw_cal_q, pitch: pitch_cal_q, roll: roll_cal_q, elev: elev_cal_q};

	always_comb begin
		case (reg_idx)
			REG_YAW:   prdata = {2'd0, yaw_cal_q};
			REG_PITCH: prdata = {2'd0, pitch_cal_q};
			REG_ROLL:  prdata = {2'd0, roll_cal_q};
			REG_ELEV:  prdata = {12'd0, elev_cal_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_cal_q   <= YAW_CAL_RST;
			pitch_cal_q <= PITCH_CAL_RST;
			roll_cal_q  <= ROLL_CAL_RST;
			elev_cal_q  <= ELEV_CAL_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_YAW:   yaw_cal_q   <= pwdata[29:0];
				REG_PITCH: pitch_cal_q <= pwdata[29:0];
				REG_ROLL:  roll_cal_q  <= pwdata[29:0];
				REG_ELEV:  elev_cal_q  <= pwdata[19:0];
				default:   yaw_cal_q   <= yaw_cal_q;
			endcase
		end
	end

	jac_front #(
		.ADC_BITS  (ADC_BITS),
		.OVERSAMPLE(OVERSAMPLE),
		.SUM_W     (SUM_W),
		.CNT_W     (CNT_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.mode        (mode),
		.q_push      (q_push),
		.q_data      (q_push_data),
		.q_ready     (q_ready)
	);

	jac_fifo #(
		.W(SUM_W + 2)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.push_ready(q_ready),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.pop_valid (q_valid)
	);

	jac_back #(
		.ADC_BITS  (ADC_BITS),
		.OVERSAMPLE(OVERSAMPLE),
		.OUT_BITS  (OUT_BITS),
		.SUM_W     (SUM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_pop_data),
		.cal         (cal),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.axis        (axis),
		.position    (position),
		.cal_error   (cal_error)
	);

	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> q_ready)
		else $error("queue push while full");

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("queue pop while empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && cal_error |-> position == 9'sd0)
		else $error("calibration error with nonzero position");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && axis == AXIS_ELEV && OUT_BITS <= 8 |-> !position[8])
		else $error("negative elevation position");

endmodule
